>>> sv/bpcv_pkg.sv
// Shared constants, payload types and header lookup for the bitmap packet CRC validator.
package bpcv_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int COUNT_W      = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [3:0] SIZE_FIELD_END = 4'd12;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] MAGIC_0   = 8'h4D;
    localparam logic [7:0] MAGIC_1   = 8'h41;
    localparam logic [7:0] MAGIC_2   = 8'h42;
    localparam logic [7:0] MAGIC_3   = 8'h31;
    localparam logic [7:0] DIM_SMALL = 8'd60;
    localparam logic [7:0] DIM_LARGE = 8'd88;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
    } in_payload_t;

    typedef struct packed {
        logic        packet_valid;
        logic [31:0] payload_crc;
    } out_payload_t;

    function automatic logic [7:0] header_want(
        input logic [3:0]  idx,
        input logic [15:0] small_size,
        input logic [15:0] large_size
    );
        logic [7:0] want;
        case (idx)
            4'd0:    want = MAGIC_0;
            4'd1:    want = MAGIC_1;
            4'd2:    want = MAGIC_2;
            4'd3:    want = MAGIC_3;
            4'd4:    want = DIM_SMALL;
            4'd5:    want = DIM_SMALL;
            4'd6:    want = DIM_LARGE;
            4'd7:    want = DIM_LARGE;
            4'd8:    want = small_size[15:8];
            4'd9:    want = small_size[7:0];
            4'd10:   want = large_size[15:8];
            4'd11:   want = large_size[7:0];
            default: want = 8'h00;
        endcase
        return want;
    endfunction

endpackage

>>> sv/bpcv_stream_if.sv
// Valid/ready stream interface carrying one payload struct per transaction.
interface bpcv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/bpcv_crc_byte.sv
// One-byte update of the reflected CRC-32, unrolled over the eight bit steps.
module bpcv_crc_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (bpcv_pkg::CRC_POLY & {32{c[0]}});
        end
        crc_out = c;
    end

endmodule

>>> sv/bitmap_packet_crc_validator.sv
// Top level: bitmap packet header, length and payload CRC-32 validator.
//
//  channel  | modport | payload                          | transaction
//  ---------+---------+----------------------------------+----------------------------
//  packet   | sink    | packet_byte[7:0], end_of_packet  | one packet byte
//  result   | source  | packet_valid, payload_crc[31:0]  | one verdict per final byte
//
//  One byte per cycle sustained while no final byte waits; the byte lands in an input register,
//  from which the header, count and CRC state and, on a final byte, the result register are updated.
//  A final byte waits in the input register while an earlier verdict is still untaken.
//  rst_n clears the valid flags and all packet state at once; no clearing pass.
//  packet.ready drops only while a final byte waits behind an untaken result.
module bitmap_packet_crc_validator #(
    parameter int SMALL_BYTES  = 450,
    parameter int LARGE_BYTES  = 968,
    parameter int PACKET_BYTES = 1434
) (
    input  logic          clk,
    input  logic          rst_n,
    bpcv_stream_if.sink   packet,
    bpcv_stream_if.source result
);

    localparam int CW = bpcv_pkg::COUNT_W;
    localparam logic [CW:0] PAYLOAD_START = (CW+1)'(bpcv_pkg::HEADER_BYTES);
    localparam logic [CW:0] PAYLOAD_END =
        (CW+1)'(bpcv_pkg::HEADER_BYTES + SMALL_BYTES + LARGE_BYTES);
    localparam logic [CW-1:0] LAST_INDEX = CW'(PACKET_BYTES - 1);
    localparam logic [15:0] SMALL_SIZE = 16'(SMALL_BYTES);
    localparam logic [15:0] LARGE_SIZE = 16'(LARGE_BYTES);
    localparam logic [CW-1:0] CRC_FIELD_END = CW'(bpcv_pkg::HEADER_BYTES);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   crc_reg, crc_next;
    logic          hdr_ok_reg, hdr_ok_next;
    logic [31:0]   exp_crc_reg, exp_crc_next;

    logic        out_valid_reg;
    logic        out_ok_reg, out_ok_next;
    logic [31:0] out_crc_reg, out_crc_next;

    logic        s1_advance;
    logic        crc_en;
    logic [31:0] crc_upd;
    logic [CW:0] idx_ext;

    assign s1_advance   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign packet.ready = !s1_valid_reg || s1_advance;
    assign idx_ext      = {1'b0, count_reg};

    assign crc_en = (count_reg != bpcv_pkg::COUNT_MAX) && (idx_ext >= PAYLOAD_START)
                 && (idx_ext < PAYLOAD_END);

    bpcv_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (s1_byte_reg),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        logic [31:0] crc_upd_sel;
        logic        hdr_ok_upd;
        logic [31:0] exp_upd;
        crc_upd_sel = crc_en ? crc_upd : crc_reg;
        hdr_ok_upd  = hdr_ok_reg;
        exp_upd     = exp_crc_reg;
        if (count_reg < CW'(bpcv_pkg::SIZE_FIELD_END))
        begin
            if (bpcv_pkg::header_want(count_reg[3:0], SMALL_SIZE, LARGE_SIZE) != s1_byte_reg)
            begin
                hdr_ok_upd = 1'b0;
            end
        end
        else if (count_reg < CRC_FIELD_END)
        begin
            exp_upd = {exp_crc_reg[23:0], s1_byte_reg};
        end

        out_ok_next  = hdr_ok_upd && (count_reg != bpcv_pkg::COUNT_MAX)
                    && (count_reg == LAST_INDEX) && (~crc_upd_sel == exp_upd);
        out_crc_next = ~crc_upd_sel;

        if (s1_last_reg)
        begin
            count_next   = '0;
            crc_next     = bpcv_pkg::CRC_INIT;
            hdr_ok_next  = 1'b1;
            exp_crc_next = '0;
        end
        else
        begin
            count_next   = (count_reg == bpcv_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
            crc_next     = crc_upd_sel;
            hdr_ok_next  = hdr_ok_upd;
            exp_crc_next = exp_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (packet.ready)
        begin
            s1_valid_reg <= packet.valid;
            s1_last_reg  <= packet.payload.end_of_packet;
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet.ready && packet.valid)
        begin
            s1_byte_reg <= packet.payload.packet_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= bpcv_pkg::CRC_INIT;
            hdr_ok_reg  <= 1'b1;
            exp_crc_reg <= '0;
        end
        else if (s1_advance)
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            hdr_ok_reg  <= hdr_ok_next;
            exp_crc_reg <= exp_crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            out_ok_reg  <= out_ok_next;
            out_crc_reg <= out_crc_next;
        end
    end

    assign result.valid                = out_valid_reg;
    assign result.payload.packet_valid = out_ok_reg;
    assign result.payload.payload_crc  = out_crc_reg;

endmodule

>>> sv/bpcv_checker.sv
// Port-level assertions for the validator and the bind that attaches them.
module bpcv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_packet_valid,
    input logic [31:0] out_crc
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a stalled result");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_packet_valid) && $stable(out_crc)))
        else $error("result payload changed while stalled");

endmodule

bind bitmap_packet_crc_validator bpcv_checker u_bpcv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (packet.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_packet_valid (result.payload.packet_valid),
    .out_crc          (result.payload.payload_crc)
);
